// File: rtl/oomr_pkg.sv
// Package with the sizes, request codes and index helpers of the overwrite-oldest message ring.
package oomr_pkg;

  localparam int SLOTS       = 8;
  localparam int SLOT_BYTES  = 512;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = $clog2(SLOT_BYTES + 1);
  localparam int STORE_DEPTH = SLOTS * SLOT_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);

  localparam logic [1:0] REQ_ENQUEUE = 2'd0;
  localparam logic [1:0] REQ_PEEK    = 2'd1;
  localparam logic [1:0] REQ_POP     = 2'd2;
  localparam logic [1:0] REQ_STATUS  = 2'd3;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(SLOTS - 1)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] held_count(input logic [SLOT_W-1:0] tail,
                                                   input logic [SLOT_W-1:0] head);
    logic [SLOT_W:0] wrapped;
    wrapped = (SLOT_W+1)'(tail) + (SLOT_W+1)'(SLOTS) - (SLOT_W+1)'(head);
    return (tail >= head) ? tail - head : SLOT_W'(wrapped);
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [STORE_AW-1:0] offset);
    return STORE_AW'(STORE_AW'(slot) * STORE_AW'(SLOT_BYTES)) + offset;
  endfunction

endpackage

// File: rtl/oomr_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module oomr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/overwrite_oldest_message_ring.sv
// Top level of the overwrite-oldest message ring: pointers, pending message and result register.
//
//   Channel   Handshake              Payload
//   command   start, busy            req_type, data_byte, has_byte, last_byte, byte_index
//   result    done (one-cycle pulse) ok, out_byte, head_length, entry_count, tail_index,
//                                    dropped_oldest, rejected
//
// Each transaction runs through these steps: acceptance with the memory writes (ST_IDLE), a read of the
// length and byte memories (ST_READ), and ST_FORM, in which the result register is loaded.
// The registered read port of those memories sets these steps; a new command is
// accepted in the cycle in which done is high.
// Reset clears the pointers, the pending message and the controller; the memories are not
// cleared. Each result is flagged by done for exactly one cycle and the receiver cannot stall it.
module overwrite_oldest_message_ring (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type,
  input  logic [7:0] data_byte,
  input  logic       has_byte,
  input  logic       last_byte,
  input  logic [8:0] byte_index,
  output logic       done,
  output logic       ok,
  output logic [7:0] out_byte,
  output logic [9:0] head_length,
  output logic [2:0] entry_count,
  output logic [2:0] tail_index,
  output logic       dropped_oldest,
  output logic       rejected
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FORM
  } state_t;

  state_t                              state;
  logic [oomr_pkg::SLOT_W-1:0]         head;
  logic [oomr_pkg::SLOT_W-1:0]         tail;
  logic [oomr_pkg::CNT_W-1:0]          pending_count;
  logic                                pending_overflow;
  logic [1:0]                          req_r;
  logic [8:0]                          idx_r;
  logic                                ok_r;
  logic                                dropped_r;
  logic                                rejected_r;

  logic                                accept;
  logic                                is_enq;
  logic [oomr_pkg::SLOT_W-1:0]         tail_next;
  logic [oomr_pkg::SLOT_W-1:0]         head_next;
  logic                                byte_fits;
  logic                                store_we;
  logic [oomr_pkg::STORE_AW-1:0]       store_waddr;
  logic [oomr_pkg::STORE_AW-1:0]       store_raddr;
  logic [7:0]                          store_rdata;
  logic [oomr_pkg::CNT_W-1:0]          count_next;
  logic                                overflow_next;
  logic                                commit;
  logic                                drop;
  logic                                nonempty;
  logic [oomr_pkg::CNT_W-1:0]          len_rdata;
  logic [oomr_pkg::SLOT_W-1:0]         held_now;
  logic                                peek_hit;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign is_enq    = (req_type == oomr_pkg::REQ_ENQUEUE);
  assign tail_next = oomr_pkg::next_slot(tail);
  assign head_next = oomr_pkg::next_slot(head);
  assign byte_fits = (pending_count < oomr_pkg::CNT_W'(oomr_pkg::SLOT_BYTES));

  assign store_we      = accept && is_enq && has_byte && byte_fits;
  assign store_waddr   = oomr_pkg::store_addr(tail_next, oomr_pkg::STORE_AW'(pending_count));
  assign store_raddr   = oomr_pkg::store_addr(head_next, oomr_pkg::STORE_AW'(idx_r));
  assign count_next    = pending_count + oomr_pkg::CNT_W'(has_byte && byte_fits);
  assign overflow_next = pending_overflow || (has_byte && !byte_fits);
  assign commit        = accept && is_enq && last_byte && !overflow_next;
  assign drop          = commit && (oomr_pkg::next_slot(tail_next) == head);
  assign nonempty      = (oomr_pkg::held_count(tail, head) != '0);
  assign held_now      = oomr_pkg::held_count(tail, head);

  assign peek_hit = (req_r == oomr_pkg::REQ_PEEK) && ok_r
                 && (int'(idx_r) < int'(len_rdata))
                 && (int'(idx_r) < oomr_pkg::SLOT_BYTES);

  oomr_ram #(
    .WIDTH(8),
    .DEPTH(oomr_pkg::STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (store_we),
    .waddr(store_waddr),
    .wdata(data_byte),
    .raddr(store_raddr),
    .rdata(store_rdata)
  );

  oomr_ram #(
    .WIDTH(oomr_pkg::CNT_W),
    .DEPTH(oomr_pkg::SLOTS)
  ) u_length (
    .clk  (clk),
    .we   (commit),
    .waddr(tail_next),
    .wdata(count_next),
    .raddr(head_next),
    .rdata(len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      head             <= '0;
      tail             <= '0;
      pending_count    <= '0;
      pending_overflow <= 1'b0;
      done             <= 1'b0;
    end else begin
      done <= (state == ST_FORM);
      case (state)
        ST_IDLE: begin
          if (accept) begin
            req_r      <= req_type;
            idx_r      <= byte_index;
            ok_r       <= is_enq ? commit : nonempty;
            dropped_r  <= drop;
            rejected_r <= is_enq && last_byte && overflow_next;
            state      <= ST_READ;
            if (is_enq) begin
              if (last_byte) begin
                pending_count    <= '0;
                pending_overflow <= 1'b0;
              end else begin
                pending_count    <= count_next;
                pending_overflow <= overflow_next;
              end
              if (commit) begin
                tail <= tail_next;
              end
              if (drop) begin
                head <= head_next;
              end
            end else if (req_type == oomr_pkg::REQ_POP && nonempty) begin
              head <= head_next;
            end
          end
        end
        ST_READ: begin
          state <= ST_FORM;
        end
        ST_FORM: begin
          ok             <= ok_r;
          out_byte       <= peek_hit ? store_rdata : 8'd0;
          head_length    <= (held_now != '0) ? 10'(len_rdata) : 10'd0;
          entry_count    <= 3'(held_now);
          tail_index     <= 3'(tail);
          dropped_oldest <= dropped_r;
          rejected       <= rejected_r;
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/oomr_checker.sv
// Port-level checker for the overwrite-oldest message ring and its bind to the top level.
module oomr_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       ok,
  input logic       dropped_oldest,
  input logic       rejected,
  input logic [2:0] entry_count
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe not at the end of a busy period");

  a_reject_excl: assert property (@(posedge clk) disable iff (rst)
    done && rejected |-> !ok && !dropped_oldest)
    else $error("rejected message reported as committed");

  a_drop_commit: assert property (@(posedge clk) disable iff (rst)
    done && dropped_oldest |-> ok && (entry_count == 3'(oomr_pkg::SLOTS - 2)))
    else $error("oldest message dropped without a full committed ring");

endmodule

bind overwrite_oldest_message_ring oomr_checker u_oomr_checker (.*);
